>>> sv/ild_pkg.sv
// Shared types, constants and opcode descriptor tables for the x86 length decoder.
// No dependencies; used by ild_step.sv and x86_instruction_length_decoder_top.sv.
package ild_pkg;

  // Descriptor bits
  localparam logic [7:0] D_IMM8   = 8'h01;
  localparam logic [7:0] D_IMM    = 8'h02;
  localparam logic [7:0] D_MOFFS  = 8'h04;
  localparam logic [7:0] D_BRANCH = 8'h20;
  localparam logic [7:0] D_MODRM  = 8'h40;
  localparam logic [7:0] D_KNOWN  = 8'h80;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_OPSIZE  = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  // Opcode bytes with special handling
  localparam logic [7:0] OP_ESC    = 8'h0f;
  localparam logic [7:0] OP_OPSIZE = 8'h66;
  localparam logic [7:0] OP_C7     = 8'hc7;
  localparam logic [7:0] OP_F6     = 8'hf6;
  localparam logic [7:0] OP_F7     = 8'hf7;
  localparam logic [7:0] MODRM_F8  = 8'hf8;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_OPC2   = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_DISP   = 3'd4,
    PH_IMM    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ACT_MORE = 2'd0,
    ACT_OK   = 2'd1,
    ACT_UNK  = 2'd2,
    ACT_OSZ  = 2'd3
  } act_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_in_block;
  } ild_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] length;
    logic [7:0] rel_offset;
    logic [2:0] rel_size;
  } ild_out_t;

  typedef struct packed {
    phase_t     phase;
    logic       rex_w_seen;
    logic       size_override;
    logic       two_byte_map;
    logic [7:0] opcode_held;
    logic [7:0] descriptor;
    logic [7:0] modrm_held;
    logic [7:0] byte_count;
    logic [3:0] bytes_left;
    logic [7:0] rel_start;
    logic [2:0] rel_width;
    logic       skip_block;
  } ild_state_t;

  localparam ild_state_t STATE_RESET = '{
    phase: PH_PREFIX, rex_w_seen: 1'b0, size_override: 1'b0, two_byte_map: 1'b0,
    opcode_held: 8'h00, descriptor: 8'h00, modrm_held: 8'h00, byte_count: 8'h00,
    bytes_left: 4'h0, rel_start: 8'h00, rel_width: 3'd0, skip_block: 1'b0
  };

  // One-byte opcode map descriptor
  function automatic logic [7:0] rom_one(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    priority if (b < 8'h40) begin
      if (b[2:0] <= 3'd3)      d = D_KNOWN | D_MODRM;
      else if (b[2:0] == 3'd4) d = D_KNOWN | D_IMM8;
      else if (b[2:0] == 3'd5) d = D_KNOWN | D_IMM;
      else                     d = 8'h00;
    end
    else if (b >= 8'h50 && b <= 8'h5f) d = D_KNOWN;
    else if (b == 8'h63) d = D_KNOWN | D_MODRM;
    else if (b == 8'h68) d = D_KNOWN | D_IMM;
    else if (b == 8'h69) d = D_KNOWN | D_MODRM | D_IMM;
    else if (b == 8'h6a) d = D_KNOWN | D_IMM8;
    else if (b == 8'h6b) d = D_KNOWN | D_MODRM | D_IMM8;
    else if (b >= 8'h6c && b <= 8'h6f) d = D_KNOWN;
    else if (b >= 8'h70 && b <= 8'h7f) d = D_KNOWN | D_BRANCH | D_IMM8;
    else if (b == 8'h80 || b == 8'h83) d = D_KNOWN | D_MODRM | D_IMM8;
    else if (b == 8'h81) d = D_KNOWN | D_MODRM | D_IMM;
    else if (b >= 8'h84 && b <= 8'h8e) d = D_KNOWN | D_MODRM;
    else if ((b >= 8'h90 && b <= 8'h99) || (b >= 8'h9b && b <= 8'h9f)) d = D_KNOWN;
    else if (b >= 8'ha0 && b <= 8'ha3) d = D_KNOWN | D_MOFFS;
    else if ((b >= 8'ha4 && b <= 8'ha7) || (b >= 8'haa && b <= 8'haf)) d = D_KNOWN;
    else if (b == 8'ha8) d = D_KNOWN | D_IMM8;
    else if (b == 8'ha9) d = D_KNOWN | D_IMM;
    else if (b >= 8'hb0 && b <= 8'hb7) d = D_KNOWN | D_IMM8;
    else if (b >= 8'hb8 && b <= 8'hbf) d = D_KNOWN | D_IMM;
    else if (b == 8'hc0 || b == 8'hc1 || b == 8'hc6) d = D_KNOWN | D_MODRM | D_IMM8;
    else if (b == 8'hc3 || b == 8'hcb || b == 8'hcc) d = D_KNOWN;
    else if (b == 8'hc7) d = D_KNOWN | D_MODRM | D_IMM;
    else if (b == 8'hcd) d = D_KNOWN | D_IMM8;
    else if (b >= 8'hd0 && b <= 8'hd3) d = D_KNOWN | D_MODRM;
    else if (b >= 8'he4 && b <= 8'he7) d = D_KNOWN | D_IMM8;
    else if (b == 8'he8 || b == 8'he9) d = D_KNOWN | D_BRANCH | D_IMM;
    else if (b == 8'heb) d = D_KNOWN | D_BRANCH | D_IMM8;
    else if (b >= 8'hec && b <= 8'hef) d = D_KNOWN;
    else if (b == 8'hf1 || b == 8'hf4 || b == 8'hf5) d = D_KNOWN;
    else if (b == 8'hf6 || b == 8'hf7 || b == 8'hfe || b == 8'hff) d = D_KNOWN | D_MODRM;
    else if (b >= 8'hf8 && b <= 8'hfd) d = D_KNOWN;
    else d = 8'h00;
    return d;
  endfunction

  // Two-byte (0x0f escape) opcode map descriptor
  function automatic logic [7:0] rom_two(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    priority if (b <= 8'h03) d = D_KNOWN | D_MODRM;
    else if (b == 8'h06 || b == 8'h09 || b == 8'h0b) d = D_KNOWN;
    else if (b >= 8'h18 && b <= 8'h23) d = D_KNOWN | D_MODRM;
    else if (b >= 8'h30 && b <= 8'h33) d = D_KNOWN;
    else if (b >= 8'h40 && b <= 8'h4f) d = D_KNOWN | D_MODRM;
    else if (b >= 8'h80 && b <= 8'h8f) d = D_KNOWN | D_BRANCH | D_IMM;
    else if (b >= 8'h90 && b <= 8'h9f) d = D_KNOWN | D_MODRM;
    else if ((b >= 8'ha0 && b <= 8'ha2) || b == 8'ha8 || b == 8'ha9) d = D_KNOWN;
    else if (b == 8'ha4 || b == 8'hac || b == 8'hba) d = D_KNOWN | D_MODRM | D_IMM8;
    else if (b == 8'ha3 || b == 8'ha5 || b == 8'hab) d = D_KNOWN | D_MODRM;
    else if (b >= 8'had && b <= 8'hb9) d = D_KNOWN | D_MODRM;
    else if ((b >= 8'hbb && b <= 8'hc1) || b == 8'hc7) d = D_KNOWN | D_MODRM;
    else if (b >= 8'hc8 && b <= 8'hcf) d = D_KNOWN;
    else d = 8'h00;
    return d;
  endfunction

endpackage

>>> sv/x86_instruction_length_decoder_top.sv
// Top level of the x86 instruction length decoder: input register, decode state, result register.
// Depends on ild_pkg and ild_step.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------------
//  byte     | in  | byte_valid / byte_stall | byte_item: code_byte, last_in_block
//  res      | out | res_valid / res_stall   | res_item: status, length, rel_offset, rel_size
//
// One code byte per cycle sustained while the result output is not stalled. A byte is
// registered on acceptance and decoded against the held decoder state when the decode stage
// fires; its result (if any) lands in the result register at that edge, with the state update.
// Reset returns to the prefix phase with nothing held. A stalled result holds the decode stage,
// which then stalls the byte input.
module x86_instruction_length_decoder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  ild_pkg::ild_in_t  byte_item,
  output logic              res_valid,
  input  logic              res_stall,
  output ild_pkg::ild_out_t res_item
);
  import ild_pkg::*;

  logic       s1_valid;
  ild_in_t    s1_item;
  logic       s1_fire;
  ild_state_t state;
  ild_state_t state_next;
  logic       emit;
  ild_out_t   res_next;

  // Decode stage advances when the result register is free or draining
  assign s1_fire    = s1_valid && (!res_valid || !res_stall);
  assign byte_stall = s1_valid && !s1_fire;

  ild_step u_step (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .emit (emit),
    .res  (res_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_item <= byte_item;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s1_fire ? emit : (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      res_item <= res_next;
    end
  end

  // Checks
  a_empty_no_stall: assert property (@(posedge clk) !s1_valid |-> !byte_stall)
    else $error("byte input stalled with empty decode stage");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != ST_OK |-> res_item.length == 8'd0 &&
      res_item.rel_size == 3'd0 && res_item.rel_offset == 8'd0)
    else $error("error result carries length or relative field");

  a_rel_size: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.rel_size == 3'd0 || res_item.rel_size == 3'd1 ||
      res_item.rel_size == 3'd4)
    else $error("bad relative field size");

  a_reset_state: assert property (@(posedge clk)
    rst |=> state.phase == PH_PREFIX && !state.skip_block && !res_valid)
    else $error("decoder not cleared by reset");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    state.skip_block |-> state.phase == PH_PREFIX && state.byte_count == 8'd0)
    else $error("skipping block with decode in progress");

endmodule

>>> sv/ild_step.sv
// Per-byte next-state and result logic of the x86 length decoder.
// Depends on ild_pkg (state/item types, descriptor tables).
module ild_step (
  input  ild_pkg::ild_state_t cur,
  input  ild_pkg::ild_in_t    item,
  output ild_pkg::ild_state_t nxt,
  output logic                emit,
  output ild_pkg::ild_out_t   res
);
  import ild_pkg::*;

  logic [7:0] b;
  logic [1:0] md;
  logic [2:0] rg;
  logic [2:0] rm;
  logic [7:0] bc;
  logic [7:0] d;
  logic [3:0] osize;
  logic [3:0] isz;
  logic [3:0] disp_n;
  logic       do_disp;
  logic       do_aa;
  logic       movabs;
  logic [3:0] left_dec;
  act_t       act;

  assign b  = item.code_byte;
  assign md = b[7:6];
  assign rg = b[5:3];
  assign rm = b[2:0];
  assign bc = (cur.byte_count == 8'hff) ? 8'hff : cur.byte_count + 8'd1;
  assign left_dec = (cur.bytes_left != 4'd0) ? cur.bytes_left - 4'd1 : 4'd0;

  always_comb begin
    nxt     = cur;
    emit    = 1'b0;
    res     = '0;
    act     = ACT_MORE;
    do_disp = 1'b0;
    do_aa   = 1'b0;
    disp_n  = 4'd0;
    d       = 8'h00;
    osize   = 4'd4;
    isz     = 4'd0;
    movabs  = 1'b0;

    if (cur.skip_block) begin
      // Discard bytes until the block ends
      if (item.last_in_block) begin
        nxt = STATE_RESET;
      end
    end else begin
      nxt.byte_count = bc;

      // Phase handling
      unique case (cur.phase)
        PH_OPC2: begin
          d = rom_two(b);
          nxt.opcode_held = b;
          nxt.descriptor  = d;
          if ((d & D_KNOWN) == 8'h00)      act = ACT_UNK;
          else if ((d & D_MODRM) != 8'h00) nxt.phase = PH_MODRM;
          else                             do_aa = 1'b1;
        end
        PH_MODRM: begin
          nxt.modrm_held = b;
          if (!cur.two_byte_map) begin
            if (cur.opcode_held == OP_C7 && b == MODRM_F8)
              nxt.descriptor = nxt.descriptor | D_BRANCH;
            if (cur.opcode_held == OP_F6 && rg <= 3'd1)
              nxt.descriptor = nxt.descriptor | D_IMM8;
            if (cur.opcode_held == OP_F7 && rg <= 3'd1)
              nxt.descriptor = nxt.descriptor | D_IMM;
          end
          if (md == 2'd0 && rm == 3'd5) begin
            // RIP-relative displacement
            nxt.rel_start = bc;
            nxt.rel_width = 3'd4;
            do_disp = 1'b1;
            disp_n  = 4'd4;
          end else if (md != 2'd3 && rm == 3'd4) begin
            nxt.phase = PH_SIB;
          end else begin
            do_disp = 1'b1;
            disp_n  = (md == 2'd1) ? 4'd1 : ((md == 2'd2) ? 4'd4 : 4'd0);
          end
        end
        PH_SIB: begin
          do_disp = 1'b1;
          if (cur.modrm_held[7:6] == 2'd0 && b[2:0] == 3'd5) disp_n = 4'd4;
          else if (cur.modrm_held[7:6] == 2'd1)              disp_n = 4'd1;
          else if (cur.modrm_held[7:6] == 2'd2)              disp_n = 4'd4;
          else                                               disp_n = 4'd0;
        end
        PH_DISP: begin
          nxt.bytes_left = left_dec;
          if (left_dec == 4'd0) do_aa = 1'b1;
        end
        PH_IMM: begin
          nxt.bytes_left = left_dec;
          if (left_dec == 4'd0) act = ACT_OK;
        end
        default: begin
          // Prefix phase: legacy prefixes, REX, escape, or a one-byte opcode
          priority if (b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
                       b == 8'h64 || b == 8'h65 || b == 8'hf0 || b == 8'hf2 ||
                       b == 8'hf3) begin
            nxt.rex_w_seen = 1'b0;
          end else if (b == OP_OPSIZE) begin
            nxt.size_override = 1'b1;
            nxt.rex_w_seen    = 1'b0;
          end else if (b == OP_ESC) begin
            nxt.two_byte_map = 1'b1;
            nxt.phase        = PH_OPC2;
          end else if (b[7:4] == 4'h4) begin
            nxt.rex_w_seen = b[3];
          end else begin
            d = rom_one(b);
            nxt.opcode_held = b;
            nxt.descriptor  = d;
            if ((d & D_KNOWN) == 8'h00)      act = ACT_UNK;
            else if ((d & D_MODRM) != 8'h00) nxt.phase = PH_MODRM;
            else                             do_aa = 1'b1;
          end
        end
      endcase

      // Start of displacement bytes, if any
      if (do_disp) begin
        if (disp_n == 4'd0) begin
          do_aa = 1'b1;
        end else begin
          nxt.bytes_left = disp_n;
          nxt.phase      = PH_DISP;
        end
      end

      // Addressing done: branch check and immediate size
      if (do_aa) begin
        osize  = nxt.rex_w_seen ? 4'd8 : (nxt.size_override ? 4'd2 : 4'd4);
        movabs = !nxt.two_byte_map && (nxt.opcode_held[7:3] == 5'b10111);
        if ((nxt.descriptor & D_BRANCH) != 8'h00 && osize == 4'd2) begin
          act = ACT_OSZ;
        end else begin
          if ((nxt.descriptor & D_BRANCH) != 8'h00) begin
            nxt.rel_start = bc;
            nxt.rel_width = ((nxt.descriptor & D_IMM8) != 8'h00) ? 3'd1 : 3'd4;
          end
          if ((nxt.descriptor & D_IMM8) != 8'h00)       isz = 4'd1;
          else if ((nxt.descriptor & D_MOFFS) != 8'h00) isz = 4'd8;
          else if ((nxt.descriptor & D_IMM) != 8'h00)
            isz = (osize == 4'd8 && !movabs) ? 4'd4 : osize;
          else                                          isz = 4'd0;
          if (isz == 4'd0) begin
            act = ACT_OK;
          end else begin
            nxt.bytes_left = isz;
            nxt.phase      = PH_IMM;
          end
        end
      end

      // Result on instruction end, error, or block end mid-instruction
      if (act != ACT_MORE || item.last_in_block) begin
        emit = 1'b1;
        unique case (act)
          ACT_OK: begin
            res.status = ST_OK;
            res.length = bc;
            if (nxt.rel_width != 3'd0) begin
              res.rel_offset = nxt.rel_start;
              res.rel_size   = nxt.rel_width;
            end
          end
          ACT_MORE: res.status = ST_OVERRUN;
          ACT_UNK:  res.status = ST_UNKNOWN;
          default:  res.status = ST_OPSIZE;
        endcase
        nxt = STATE_RESET;
        nxt.skip_block = (act == ACT_UNK || act == ACT_OSZ) && !item.last_in_block;
      end
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for x86_instruction_length_decoder_top: streams code bytes,
// predicts each length/status result in place and checks results in order. Needs ild_pkg.
module testbench;
  import ild_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 29;
  localparam logic [7:0] LEGACY_PREFIXES [9] = '{8'h26, 8'h2e, 8'h36, 8'h3e, 8'h64,
                                                 8'h65, 8'hf0, 8'hf2, 8'hf3};

  typedef logic [7:0] byte_seq_t[$];

  // Decoder state as the predictor sees it
  typedef struct packed {
    phase_t     ph;
    logic       rexw;
    logic       opsz16;
    logic       esc_map;
    logic [7:0] opc;
    logic [7:0] desc;
    logic [7:0] modrm;
    logic [7:0] count;
    logic [3:0] left;
    logic [7:0] rel_at;
    logic [2:0] rel_w;
    logic       skipping;
  } decoder_state_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  ild_in_t   byte_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  ild_out_t  res_item;

  decoder_state_t dec = '0;
  ild_out_t  expected_results[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;

  x86_instruction_length_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Opcode classification
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] one_byte_desc(input logic [7:0] b);
    logic [3:0] lo;
    lo = b[3:0];
    case (b[7:4])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        if (b[2:0] <= 3'd3)      return D_KNOWN | D_MODRM;
        else if (b[2:0] == 3'd4) return D_KNOWN | D_IMM8;
        else if (b[2:0] == 3'd5) return D_KNOWN | D_IMM;
        return 8'h00;
      end
      4'h5: return D_KNOWN;
      4'h6: begin
        case (lo)
          4'h3:                   return D_KNOWN | D_MODRM;
          4'h8:                   return D_KNOWN | D_IMM;
          4'h9:                   return D_KNOWN | D_MODRM | D_IMM;
          4'ha:                   return D_KNOWN | D_IMM8;
          4'hb:                   return D_KNOWN | D_MODRM | D_IMM8;
          4'hc, 4'hd, 4'he, 4'hf: return D_KNOWN;
          default:                return 8'h00;
        endcase
      end
      4'h7: return D_KNOWN | D_BRANCH | D_IMM8;
      4'h8: begin
        if (lo == 4'h0 || lo == 4'h3) return D_KNOWN | D_MODRM | D_IMM8;
        if (lo == 4'h1)               return D_KNOWN | D_MODRM | D_IMM;
        if (lo >= 4'h4 && lo <= 4'he) return D_KNOWN | D_MODRM;
        return 8'h00;
      end
      4'h9: return (lo == 4'ha) ? 8'h00 : D_KNOWN;
      4'ha: begin
        if (lo <= 4'h3) return D_KNOWN | D_MOFFS;
        if (lo == 4'h8) return D_KNOWN | D_IMM8;
        if (lo == 4'h9) return D_KNOWN | D_IMM;
        return D_KNOWN;
      end
      4'hb: return (lo <= 4'h7) ? (D_KNOWN | D_IMM8) : (D_KNOWN | D_IMM);
      4'hc: begin
        case (lo)
          4'h0, 4'h1, 4'h6: return D_KNOWN | D_MODRM | D_IMM8;
          4'h3, 4'hb, 4'hc: return D_KNOWN;
          4'h7:             return D_KNOWN | D_MODRM | D_IMM;
          4'hd:             return D_KNOWN | D_IMM8;
          default:          return 8'h00;
        endcase
      end
      4'hd: return (lo <= 4'h3) ? (D_KNOWN | D_MODRM) : 8'h00;
      4'he: begin
        if (lo >= 4'h4 && lo <= 4'h7) return D_KNOWN | D_IMM8;
        if (lo == 4'h8 || lo == 4'h9) return D_KNOWN | D_BRANCH | D_IMM;
        if (lo == 4'hb)               return D_KNOWN | D_BRANCH | D_IMM8;
        if (lo >= 4'hc)               return D_KNOWN;
        return 8'h00;
      end
      4'hf: begin
        case (lo)
          4'h1, 4'h4, 4'h5:             return D_KNOWN;
          4'h6, 4'h7, 4'he, 4'hf:       return D_KNOWN | D_MODRM;
          4'h8, 4'h9, 4'ha, 4'hb, 4'hc, 4'hd: return D_KNOWN;
          default:                      return 8'h00;
        endcase
      end
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] two_byte_desc(input logic [7:0] b);
    logic [3:0] lo;
    lo = b[3:0];
    case (b[7:4])
      4'h0: begin
        if (lo <= 4'h3) return D_KNOWN | D_MODRM;
        if (lo == 4'h6 || lo == 4'h9 || lo == 4'hb) return D_KNOWN;
        return 8'h00;
      end
      4'h1: return (lo >= 4'h8) ? (D_KNOWN | D_MODRM) : 8'h00;
      4'h2: return (lo <= 4'h3) ? (D_KNOWN | D_MODRM) : 8'h00;
      4'h3: return (lo <= 4'h3) ? D_KNOWN : 8'h00;
      4'h4, 4'h9: return D_KNOWN | D_MODRM;
      4'h8: return D_KNOWN | D_BRANCH | D_IMM;
      4'ha: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h8, 4'h9:   return D_KNOWN;
          4'h4, 4'hc:                     return D_KNOWN | D_MODRM | D_IMM8;
          4'h3, 4'h5, 4'hb, 4'hd, 4'he, 4'hf: return D_KNOWN | D_MODRM;
          default:                        return 8'h00;
        endcase
      end
      4'hb: return (lo == 4'ha) ? (D_KNOWN | D_MODRM | D_IMM8) : (D_KNOWN | D_MODRM);
      4'hc: begin
        if (lo <= 4'h1 || lo == 4'h7) return D_KNOWN | D_MODRM;
        if (lo >= 4'h8)               return D_KNOWN;
        return 8'h00;
      end
      default: return 8'h00;
    endcase
  endfunction

  function automatic bit is_legacy_prefix(input logic [7:0] b);
    foreach (LEGACY_PREFIXES[i]) if (LEGACY_PREFIXES[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Length prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_insn();
    logic keep_skip;
    keep_skip = dec.skipping;
    dec = '0;
    dec.ph = PH_PREFIX;
    dec.skipping = keep_skip;
  endfunction

  // Runs once addressing bytes are done: branch size check, then immediate size
  function automatic act_t finish_address();
    logic [3:0] osize;
    logic [3:0] isz;
    bit         movabs;
    osize = dec.rexw ? 4'd8 : (dec.opsz16 ? 4'd2 : 4'd4);
    isz = 4'd0;
    if ((dec.desc & D_BRANCH) != 0) begin
      if (osize < 4'd4) return ACT_OSZ;
      dec.rel_at = dec.count;
      dec.rel_w  = ((dec.desc & D_IMM8) != 0) ? 3'd1 : 3'd4;
    end
    if ((dec.desc & D_IMM8) != 0)       isz = 4'd1;
    else if ((dec.desc & D_MOFFS) != 0) isz = 4'd8;
    else if ((dec.desc & D_IMM) != 0) begin
      movabs = !dec.esc_map && dec.opc[7:3] == 5'b10111;
      isz = (osize == 4'd8 && !movabs) ? 4'd4 : osize;
    end
    if (isz == 4'd0) return ACT_OK;
    dec.left = isz;
    dec.ph   = PH_IMM;
    return ACT_MORE;
  endfunction

  function automatic act_t start_disp(input logic [3:0] n);
    if (n == 4'd0) return finish_address();
    dec.left = n;
    dec.ph   = PH_DISP;
    return ACT_MORE;
  endfunction

  function automatic act_t take_opcode(input logic [7:0] b, input logic [7:0] d);
    dec.opc  = b;
    dec.desc = d;
    if ((d & D_KNOWN) == 0) return ACT_UNK;
    if ((d & D_MODRM) != 0) begin
      dec.ph = PH_MODRM;
      return ACT_MORE;
    end
    return finish_address();
  endfunction

  function automatic act_t take_modrm(input logic [7:0] b);
    logic [1:0] md;
    logic [2:0] rg;
    logic [2:0] rm;
    md = b[7:6];
    rg = b[5:3];
    rm = b[2:0];
    dec.modrm = b;
    // group opcodes whose ModRM reg field changes the layout
    if (!dec.esc_map) begin
      if (dec.opc == OP_C7 && b == MODRM_F8) dec.desc |= D_BRANCH;
      if (dec.opc == OP_F6 && rg <= 3'd1)    dec.desc |= D_IMM8;
      if (dec.opc == OP_F7 && rg <= 3'd1)    dec.desc |= D_IMM;
    end
    if (md == 2'd0 && rm == 3'd5) begin
      dec.rel_at = dec.count;
      dec.rel_w  = 3'd4;
      return start_disp(4'd4);
    end
    if (md != 2'd3 && rm == 3'd4) begin
      dec.ph = PH_SIB;
      return ACT_MORE;
    end
    return start_disp(md == 2'd1 ? 4'd1 : (md == 2'd2 ? 4'd4 : 4'd0));
  endfunction

  function automatic act_t take_sib(input logic [7:0] b);
    logic [1:0] md;
    md = dec.modrm[7:6];
    if (md == 2'd0 && b[2:0] == 3'd5) return start_disp(4'd4);
    return start_disp(md == 2'd1 ? 4'd1 : (md == 2'd2 ? 4'd4 : 4'd0));
  endfunction

  function automatic act_t take_prefix(input logic [7:0] b);
    if (is_legacy_prefix(b)) begin
      dec.rexw = 1'b0;
      return ACT_MORE;
    end
    if (b == OP_OPSIZE) begin
      dec.opsz16 = 1'b1;
      dec.rexw   = 1'b0;
      return ACT_MORE;
    end
    if (b == OP_ESC) begin
      dec.esc_map = 1'b1;
      dec.ph      = PH_OPC2;
      return ACT_MORE;
    end
    if (b[7:4] == 4'h4) begin
      dec.rexw = b[3];
      return ACT_MORE;
    end
    return take_opcode(b, one_byte_desc(b));
  endfunction

  // Advances the predicted state by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input ild_in_t it, output ild_out_t r);
    act_t act;
    r = '0;
    if (dec.skipping) begin
      if (it.last_in_block) begin
        dec.skipping = 1'b0;
        clear_insn();
      end
      return 1'b0;
    end
    if (dec.count != 8'hff) dec.count++;
    case (dec.ph)
      PH_OPC2:  act = take_opcode(it.code_byte, two_byte_desc(it.code_byte));
      PH_MODRM: act = take_modrm(it.code_byte);
      PH_SIB:   act = take_sib(it.code_byte);
      PH_DISP: begin
        if (dec.left != 0) dec.left--;
        act = (dec.left != 0) ? ACT_MORE : finish_address();
      end
      PH_IMM: begin
        if (dec.left != 0) dec.left--;
        act = (dec.left != 0) ? ACT_MORE : ACT_OK;
      end
      default:  act = take_prefix(it.code_byte);
    endcase
    if (act == ACT_MORE && !it.last_in_block) return 1'b0;
    case (act)
      ACT_OK: begin
        r.status = ST_OK;
        r.length = dec.count;
        if (dec.rel_w != 0) begin
          r.rel_offset = dec.rel_at;
          r.rel_size   = dec.rel_w;
        end
      end
      ACT_MORE: r.status = ST_OVERRUN;
      default: begin
        r.status = (act == ACT_UNK) ? ST_UNKNOWN : ST_OPSIZE;
        if (!it.last_in_block) dec.skipping = 1'b1;
      end
    endcase
    clear_insn();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit last);
    ild_in_t  it;
    ild_out_t r;
    it.code_byte     = b;
    it.last_in_block = last;
    // idle cycles at random before the item
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (byte_stall !== 1'b0);
    items_sent++;
    if (decode_byte(it, r)) expected_results.push_back(r);
  endtask

  // Sends a whole block; the final byte closes it
  task automatic send_block(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Holds the input off until every pending result is out
  task automatic wait_results_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Next byte of a mostly well-formed stream, steered by the predicted phase
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    int         roll;
    roll = $urandom_range(99);
    b = 8'($urandom);
    case (dec.ph)
      PH_PREFIX: begin
        if (roll < 4)       b = LEGACY_PREFIXES[$urandom_range(8)];
        else if (roll < 6)  b = OP_OPSIZE;
        else if (roll < 10) b = 8'h40 | 8'($urandom_range(15));
        else if (roll < 18) b = OP_ESC;
        else if (roll >= 22) begin
          while ((one_byte_desc(b) & D_KNOWN) == 0) b = 8'($urandom);
        end
      end
      PH_OPC2: begin
        if (roll < 92) begin
          while ((two_byte_desc(b) & D_KNOWN) == 0) b = 8'($urandom);
        end
      end
      PH_MODRM: begin
        if (!dec.esc_map && dec.opc == OP_C7 && roll < 20) b = MODRM_F8;
      end
      default: ;
    endcase
    return b;
  endfunction

  // Random blocks of a few instructions each, with truncated blocks and noise
  task automatic run_random_blocks(input int target);
    int             start;
    int             want;
    int             done_n;
    logic [7:0]     b;
    bit             last;
    ild_out_t       r;
    decoder_state_t keep;
    start = items_sent;
    while (items_sent - start < target) begin
      want   = $urandom_range(1, 6);
      done_n = 0;
      last   = 1'b0;
      while (!last) begin
        if (dec.skipping) begin
          b    = 8'($urandom);
          last = ($urandom_range(3) == 0);
        end else begin
          b    = pick_byte();
          keep = dec;
          if (decode_byte('{code_byte: b, last_in_block: 1'b0}, r)) begin
            done_n++;
            last = (done_n >= want);
          end else begin
            last = ($urandom_range(99) < 3);
          end
          dec = keep;
        end
        send_byte(b, last);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_addressing_forms();
    // RIP-relative, extreme opcodes, SIB with disp8, SIB with no base
    send_block('{8'h00, 8'h05, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hff, 8'hc0, 8'h90, 8'hc3,
                 8'h8b, 8'h44, 8'h24, 8'h08, 8'h8b, 8'h04, 8'h25, 8'h00, 8'h00, 8'h00,
                 8'h80});
    wait_results_drained();
  endtask

  task automatic test_prefix_rules();
    // 66 after REX drops W; legacy prefix after REX drops W; later REX wins
    send_block('{8'h48, 8'h66, 8'h05, 8'h11, 8'h22,
                 8'h48, 8'h2e, 8'hb8, 8'h01, 8'h02, 8'h03, 8'h04,
                 8'h40, 8'h48, 8'h05, 8'haa, 8'hbb, 8'hcc, 8'hdd,
                 8'h49, 8'h48, 8'hb8, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                 8'h08});
    wait_results_drained();
  endtask

  task automatic test_immediate_widths();
    // moffs, group 3 with and without immediate, 16-bit immediate
    send_block('{8'ha1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                 8'hf6, 8'hc0, 8'h7f, 8'hf7, 8'hd8,
                 8'hf7, 8'hc1, 8'h01, 8'h02, 8'h03, 8'h04,
                 8'h66, 8'hf7, 8'hc1, 8'hfe, 8'hff});
    wait_results_drained();
  endtask

  task automatic test_branches();
    send_block('{8'h0f, 8'h84, 8'h10, 8'h00, 8'h00, 8'h00, 8'heb, 8'h80,
                 8'hc7, 8'hf8, 8'h00, 8'h01, 8'h02, 8'h03});
    // 16-bit branch mid-block: rest of the block is dropped
    send_block('{8'h66, 8'he9, 8'h01, 8'h02, 8'h03, 8'h04});
    // 16-bit branch on the closing byte: decoding resumes right away
    send_block('{8'h66, 8'h0f, 8'h85});
    send_block('{8'h70, 8'h00});
    wait_results_drained();
  endtask

  task automatic test_error_recovery();
    send_block('{8'h67});
    send_block('{8'h06, 8'h90, 8'h90});
    send_block('{8'h0f, 8'h04, 8'h90});
    send_block('{8'he8, 8'h01, 8'h02});
    send_block('{8'h66});
    send_block('{8'h90});
    wait_results_drained();
  endtask

  task automatic test_length_saturation();
    byte_seq_t seq;
    repeat (258) seq.push_back(8'h2e);
    seq.push_back(8'he8);
    repeat (4) seq.push_back(8'h55);
    send_block(seq);
    wait_results_drained();
  endtask

  task automatic test_back_to_back_stream();
    quiet = 1'b1;
    run_random_blocks(50);
    wait_results_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random_stream();
    run_random_blocks(80);
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    ild_out_t want;
    if (res_valid === 1'b1 && res_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d length=%0d rel_offset=%0d rel_size=%0d",
                 $time, res_item.status, res_item.length, res_item.rel_offset,
                 res_item.rel_size);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   res_item.status);
          mismatches++;
        end
        if (res_item.length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length,
                   res_item.length);
          mismatches++;
        end
        if (res_item.rel_offset !== want.rel_offset) begin
          $display("%0t: rel_offset expected %0d actual %0d", $time, want.rel_offset,
                   res_item.rel_offset);
          mismatches++;
        end
        if (res_item.rel_size !== want.rel_size) begin
          $display("%0t: rel_size expected %0d actual %0d", $time, want.rel_size,
                   res_item.rel_size);
          mismatches++;
        end
      end
    end
    res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_addressing_forms();
    test_prefix_rules();
    test_immediate_widths();
    test_branches();
    test_error_recovery();
    test_length_saturation();
    test_back_to_back_stream();
    test_random_stream();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
